FILE: rtl/lfbp_pkg.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer package
// Operation and status codes, controller states and the control groups
// passed between the sequencer and the bit-serial packer.
// ----------------------------------------------------------------------------
package lfbp_pkg;

  localparam int unsigned BYTE_W = 8;

  typedef enum logic [2:0] {
    OP_BEGIN    = 3'd0,
    OP_END      = 3'd1,
    OP_BYTE     = 3'd2,
    OP_HALF     = 3'd3,
    OP_WORD     = 3'd4,
    OP_UBITS    = 3'd5,
    OP_SBITS    = 3'd6,
    OP_PAD      = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_ALREADY     = 4'd1,
    ST_NOT_ACTIVE  = 4'd2,
    ST_PENDING     = 4'd3,
    ST_BAD_COUNT   = 4'd4,
    ST_NEGATIVE    = 4'd5,
    ST_RANGE       = 4'd6,
    ST_BAD_ALIGN   = 4'd7,
    ST_RESERVED    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_PAD,
    S_PACK,
    S_STATUS
  } state_e;

  typedef enum logic [1:0] {
    ACT_STATUS,
    ACT_WORD,
    ACT_FIELD,
    ACT_PAD
  } act_e;

  typedef struct packed {
    logic load;
    logic byte_mode;
    logic take;
  } pk_ctrl_t;

  typedef struct packed {
    logic       byte_rdy;
    logic       busy;
    logic [2:0] pend_cnt;
  } pk_stat_t;

endpackage

FILE: rtl/lsb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer, top level
// Status-only items go through the status state into the output register.
// Words leave one byte per cycle, fields enter one bit per cycle (bit_count),
// and pad runs the serial remainder unit, then a zero byte per cycle, while
// the output is not stalled. Next item is taken once the status is registered.
// Reset (asynchronous, active low) clears the active flag, pending bits and
// the byte count.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top
  import lfbp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = 32,
  parameter int unsigned MAX_ALIGN      = 64,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [63:0] data_value_i,
  input  logic [5:0]         bit_count_i,
  input  logic [6:0]         alignment_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic [3:0]         status_o,
  output logic               last_o,
  output logic               stream_done_o
);

  localparam int unsigned SH_W = (MAX_FIELD_BITS > 32) ? MAX_FIELD_BITS : 32;
  localparam int unsigned CW   = $clog2(SH_W + 1);
  localparam int unsigned AW   = $clog2(MAX_ALIGN + 1);

  state_e          state_q, state_d;
  logic            active_q, active_d;
  logic [COUNT_BITS-1:0] bw_q, bw_d;
  status_e         st_q, st_d;
  logic            done_q, done_d;
  logic [AW-1:0]   align_q, align_d;
  logic [AW-1:0]   padn_q, padn_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_bv_q, out_bv_d;
  status_e         out_st_q, out_st_d;
  logic            out_last_q, out_last_d;
  logic            out_done_q, out_done_d;

  logic            accept;
  logic            out_free;
  op_e             dec_op;
  act_e            dec_act;
  status_e         dec_st;
  logic            dec_done;
  logic [CW-1:0]   dec_nbits;
  logic            over;

  pk_ctrl_t        pk_ctrl;
  pk_stat_t        pk_stat;
  logic [7:0]      pk_byte;
  logic            rem_busy;
  logic [AW-1:0]   rem_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign dec_op     = op_e'(operation_i);

  // Decode of the offered item against the current stream state.
  always_comb begin
    dec_act   = ACT_STATUS;
    dec_st    = ST_OK;
    dec_done  = 1'b0;
    dec_nbits = CW'(bit_count_i);
    over      = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (data_value_i[i] && (i >= int'(bit_count_i))) begin
        over = 1'b1;
      end
    end
    unique case (dec_op)
      OP_BEGIN: begin
        if (active_q) begin
          dec_st = ST_ALREADY;
        end
      end
      OP_END: begin
        if (!active_q) begin
          dec_st = ST_NOT_ACTIVE;
        end else if (pk_stat.pend_cnt != 3'd0) begin
          dec_st = ST_PENDING;
        end else begin
          dec_done = 1'b1;
        end
      end
      OP_BYTE, OP_HALF, OP_WORD: begin
        if (pk_stat.pend_cnt != 3'd0) begin
          dec_st = ST_PENDING;
        end else begin
          dec_act = ACT_WORD;
          if (dec_op == OP_BYTE) begin
            dec_nbits = CW'(8);
          end else if (dec_op == OP_HALF) begin
            dec_nbits = CW'(16);
          end else begin
            dec_nbits = CW'(32);
          end
        end
      end
      OP_UBITS: begin
        if (bit_count_i > 6'(MAX_FIELD_BITS)) begin
          dec_st = ST_BAD_COUNT;
        end else if (data_value_i[63]) begin
          dec_st = ST_NEGATIVE;
        end else if (over) begin
          dec_st = ST_RANGE;
        end else if (bit_count_i != 6'd0) begin
          dec_act = ACT_FIELD;
        end
      end
      OP_SBITS: begin
        if (bit_count_i == 6'd0) begin
          dec_st = ST_OK;
        end else if (bit_count_i > 6'(MAX_FIELD_BITS)) begin
          dec_st = ST_BAD_COUNT;
        end else begin
          dec_act = ACT_FIELD;
        end
      end
      OP_PAD: begin
        if (alignment_i == 7'd0 || alignment_i > 7'(MAX_ALIGN)) begin
          dec_st = ST_BAD_ALIGN;
        end else begin
          dec_act = ACT_PAD;
        end
      end
      default: dec_st = ST_RESERVED;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (dec_act)
            ACT_STATUS:           state_d = S_STATUS;
            ACT_WORD, ACT_FIELD:  state_d = S_PACK;
            ACT_PAD:              state_d = S_REM;
            default:              state_d = S_STATUS;
          endcase
        end
      end
      S_REM: begin
        if (!rem_busy) begin
          if (rem_val != '0 && pk_stat.pend_cnt == 3'd0) begin
            state_d = S_PAD;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_PAD: begin
        if (out_free && padn_q == AW'(1)) begin
          state_d = S_STATUS;
        end
      end
      S_PACK: begin
        if (!pk_stat.busy) begin
          state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    active_d    = active_q;
    bw_d        = bw_q;
    st_d        = st_q;
    done_d      = done_q;
    align_d     = align_q;
    padn_d      = padn_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_bv_d    = out_bv_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    pk_ctrl     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d              = dec_st;
          done_d            = dec_done;
          align_d           = alignment_i[AW-1:0];
          pk_ctrl.load      = (dec_act == ACT_WORD) || (dec_act == ACT_FIELD);
          pk_ctrl.byte_mode = (dec_act == ACT_WORD);
          if (dec_op == OP_BEGIN && dec_st == ST_OK) begin
            active_d = 1'b1;
            bw_d     = '0;
          end
          if (dec_done) begin
            active_d = 1'b0;
            bw_d     = '0;
          end
        end
      end
      S_REM: begin
        if (!rem_busy && rem_val != '0) begin
          if (pk_stat.pend_cnt != 3'd0) begin
            st_d = ST_PENDING;
          end else begin
            padn_d = align_q - rem_val;
          end
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'd0;
          out_bv_d    = 1'b1;
          out_st_d    = ST_OK;
          out_last_d  = 1'b0;
          out_done_d  = 1'b0;
          padn_d      = padn_q - AW'(1);
          bw_d        = bw_q + COUNT_BITS'(1);
        end
      end
      S_PACK: begin
        if (pk_stat.byte_rdy && out_free) begin
          pk_ctrl.take = 1'b1;
          out_valid_d  = 1'b1;
          out_byte_d   = pk_byte;
          out_bv_d     = 1'b1;
          out_st_d     = ST_OK;
          out_last_d   = 1'b0;
          out_done_d   = 1'b0;
          bw_d         = bw_q + COUNT_BITS'(1);
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'd0;
          out_bv_d    = 1'b0;
          out_st_d    = st_q;
          out_last_d  = 1'b1;
          out_done_d  = done_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      bw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      bw_q        <= bw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q       <= st_d;
    done_q     <= done_d;
    align_q    <= align_d;
    padn_q     <= padn_d;
    out_byte_q <= out_byte_d;
    out_bv_q   <= out_bv_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  lfbp_packer #(
    .SH_W (SH_W)
  ) u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pk_ctrl),
    .value_i (data_value_i[SH_W-1:0]),
    .nbits_i (dec_nbits),
    .stat_o  (pk_stat),
    .byte_o  (pk_byte)
  );

  lfbp_rem #(
    .DW (COUNT_BITS),
    .AW (AW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && dec_act == ACT_PAD),
    .dividend_i (bw_q),
    .divisor_i  (alignment_i[AW-1:0]),
    .busy_o     (rem_busy),
    .rem_o      (rem_val)
  );

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = out_bv_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;
  assign stream_done_o = out_done_q;

  a_idle_units_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!pk_stat.busy && !rem_busy))
    else $error("input open while a serial unit is busy");

  a_done_is_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> (last_o && !byte_valid_o && status_o == ST_OK))
    else $error("stream end flagged on a non-ok result");

  a_count_on_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && out_bv_d && !(out_valid_q && out_stall_i))
      |=> bw_q == $past(bw_q) + COUNT_BITS'(1))
    else $error("byte count missed an emitted byte");

endmodule

FILE: rtl/lfbp_rem.sv
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division of the byte count by the pad alignment, one dividend
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module lfbp_rem #(
  parameter int unsigned DW = 32,
  parameter int unsigned AW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [AW-1:0] divisor_i,
  output logic          busy_o,
  output logic [AW-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dv_q, dv_d;
  logic [AW-1:0]   div_q, div_d;
  logic [AW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [AW:0]     trial;

  always_comb begin
    dv_d   = dv_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, dv_q[DW-1]};
    if (start_i) begin
      dv_d   = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits in AW bits.
      if (trial >= {1'b0, div_q}) begin
        rem_d = AW'(trial - {1'b0, div_q});
      end else begin
        rem_d = AW'(trial);
      end
      dv_d  = dv_q << 1;
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q  <= dv_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> rem_q < div_q)
    else $error("remainder not below divisor");

endmodule

FILE: rtl/lfbp_packer.sv
// ----------------------------------------------------------------------------
// Bit-serial packer
// Moves a field into the byte accumulator one bit per cycle, or a word one
// byte per cycle unless a full byte waits; keeps pending bits between items.
// ----------------------------------------------------------------------------
module lfbp_packer
  import lfbp_pkg::*;
#(
  parameter int unsigned SH_W = 32,
  localparam int unsigned CW  = $clog2(SH_W + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pk_ctrl_t            ctrl_i,
  input  logic [SH_W-1:0]     value_i,
  input  logic [CW-1:0]       nbits_i,
  output pk_stat_t            stat_o,
  output logic [BYTE_W-1:0]   byte_o
);

  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              mode_q, mode_d;
  logic [3:0]        cur;

  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    mode_d = mode_q;
    // A taken byte frees the accumulator in the same cycle.
    cur    = ctrl_i.take ? 4'd0 : cnt_q;
    cnt_d  = cur;
    if (ctrl_i.load) begin
      sh_d   = value_i;
      rem_d  = nbits_i;
      mode_d = ctrl_i.byte_mode;
    end else if ((rem_q != '0) && !cur[3]) begin
      if (mode_q) begin
        acc_d = sh_q[BYTE_W-1:0];
        sh_d  = sh_q >> BYTE_W;
        rem_d = rem_q - CW'(BYTE_W);
        cnt_d = 4'd8;
      end else begin
        acc_d[cur[2:0]] = sh_q[0];
        sh_d  = sh_q >> 1;
        rem_d = rem_q - CW'(1);
        cnt_d = cur + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rem_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
  end

  assign stat_o.byte_rdy = cnt_q[3];
  assign stat_o.busy     = cnt_q[3] || (rem_q != '0);
  assign stat_o.pend_cnt = cnt_q[2:0];
  assign byte_o          = acc_q;

  a_word_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.load && ctrl_i.byte_mode) |-> (cnt_q == 4'd0 && rem_q == '0))
    else $error("word write started with bits pending");

endmodule
